@@ src/fir_pkg.sv @@
// shared types and constants for the fir filter
package fir_pkg;

  localparam int SAMPLE_W     = 16;
  localparam int COEFF_W      = 16;
  localparam int CIDX_W       = 4;
  localparam int TAPCNT_W     = 5;
  localparam int TAPCNT_RESET = 16;

  // request codes
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_COEFF  = 1'b1;

  typedef struct packed {
    logic                       req_type;
    logic signed [SAMPLE_W-1:0] sample;
    logic [CIDX_W-1:0]          coeff_index;
    logic signed [COEFF_W-1:0]  coeff_value;
  } fir_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] filtered;
    logic                       clipped;
  } fir_out_t;

endpackage

@@ src/fir_ram.sv @@
// generic single write port ram with registered read
module fir_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/fir_filter.sv @@
// direct-form fir filter with one shared multiply-accumulate unit
//
//   port group   direction   transaction
//   in_          in          sample to filter, or coefficient write
//   out_         out         filtered sample and clip flag
//   cfg_         in          tap count write
//
// a sample is accepted only in idle; then one multiply-accumulate runs per tap through
// the coefficient and history rams, the read, multiply and accumulate stages drain,
// and a finish step, once the output is free, rounds, saturates, registers the result
// and updates the history. no request is taken until the block is back in idle.
// reset is synchronous; valid bits make the coefficient store and the history read
// as zero until written. while a result waits on out_stall the next sample is still
// taken and runs until it has to hand over its own result.
module fir_filter #(
  parameter int MAX_TAPS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  fir_pkg::fir_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output fir_pkg::fir_out_t             out_data,
  input  logic                          cfg_wr_en,
  input  logic [fir_pkg::TAPCNT_W-1:0]  cfg_wr_data
);

  import fir_pkg::*;

  localparam int DLY_D  = MAX_TAPS - 1;
  localparam int CAW    = $clog2(MAX_TAPS);
  localparam int DAW    = (DLY_D > 1) ? $clog2(DLY_D) : 1;
  localparam int TW     = $clog2(MAX_TAPS + 1);
  localparam int PROD_W = 2 * SAMPLE_W;
  localparam int ACC_W  = PROD_W + $clog2(MAX_TAPS);
  localparam int QW     = ACC_W - 15;
  localparam logic signed [QW-1:0] Q_MAX = QW'(32767);
  localparam logic signed [QW-1:0] Q_MIN = -QW'(32768);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN,
    S_FINISH
  } state_t;

  state_t                     state_r;
  logic [TAPCNT_W-1:0]        tap_count_r;
  logic [MAX_TAPS-1:0]        coeff_vld_r;
  logic [DLY_D-1:0]           dly_vld_r;
  logic [DAW-1:0]             head_r;
  logic [DAW-1:0]             dptr_r;
  logic [TW-1:0]              cnt_r;
  logic [TW-1:0]              taps_r;
  logic [TW-1:0]              taps_nxt;
  logic signed [SAMPLE_W-1:0] x_r;
  logic                       v1_r;
  logic                       v2_r;
  logic                       sel_x1_r;
  logic                       cv1_r;
  logic                       dv1_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [ACC_W-1:0]    acc_r;
  logic                       out_valid_r;
  fir_out_t                   out_data_r;

  logic                       in_acc;
  logic                       out_free;
  logic                       c_we;
  logic [CAW-1:0]             c_waddr;
  logic [CAW-1:0]             c_raddr;
  logic [COEFF_W-1:0]         c_rdata;
  logic                       d_we;
  logic [DAW-1:0]             head_inc;
  logic [DAW-1:0]             dptr_dec;
  logic [SAMPLE_W-1:0]        d_rdata;
  logic signed [SAMPLE_W-1:0] mul_a;
  logic signed [SAMPLE_W-1:0] mul_b;
  logic signed [ACC_W-1:0]    rnd;
  logic signed [QW-1:0]       q;
  fir_out_t                   res;
  int                         tc;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || !out_stall;

  // tap count in use, held to the legal range
  always_comb begin
    tc = int'(tap_count_r);
    if (tc < 2) begin
      tc = 2;
    end
    if (tc > MAX_TAPS) begin
      tc = MAX_TAPS;
    end
    taps_nxt = TW'(tc);
  end

  assign c_we    = in_acc && (in_data.req_type == REQ_COEFF) &&
                   (32'(in_data.coeff_index) < 32'(MAX_TAPS));
  assign c_waddr = CAW'(in_data.coeff_index);
  assign c_raddr = cnt_r[CAW-1:0];

  // history is a ring: head holds the newest sample, older ones below it
  assign head_inc = (head_r == DAW'(DLY_D - 1)) ? '0 : head_r + DAW'(1);
  assign dptr_dec = (dptr_r == '0) ? DAW'(DLY_D - 1) : dptr_r - DAW'(1);
  assign d_we     = (state_r == S_FINISH) && out_free;

  fir_ram #(
    .WIDTH (COEFF_W),
    .DEPTH (MAX_TAPS),
    .AW    (CAW)
  ) u_coeff_ram (
    .clk   (clk),
    .we    (c_we),
    .waddr (c_waddr),
    .wdata (in_data.coeff_value),
    .raddr (c_raddr),
    .rdata (c_rdata)
  );

  fir_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (DLY_D),
    .AW    (DAW)
  ) u_dly_ram (
    .clk   (clk),
    .we    (d_we),
    .waddr (head_inc),
    .wdata (x_r),
    .raddr (dptr_r),
    .rdata (d_rdata)
  );

  // entries never written read as zero
  assign mul_a = cv1_r ? $signed(c_rdata) : '0;
  assign mul_b = sel_x1_r ? x_r : (dv1_r ? $signed(d_rdata) : '0);

  // round half up, then saturate
  assign rnd = acc_r + ACC_W'(16384);
  assign q   = $signed(rnd[ACC_W-1:15]);

  always_comb begin
    res.clipped = 1'b0;
    res.filtered = q[SAMPLE_W-1:0];
    if (q > Q_MAX) begin
      res.filtered = SAMPLE_W'(32767);
      res.clipped  = 1'b1;
    end else if (q < Q_MIN) begin
      res.filtered = -SAMPLE_W'(32768);
      res.clipped  = 1'b1;
    end
  end

  // mac pipeline: ram read, multiply, accumulate
  always_ff @(posedge clk) begin
    sel_x1_r <= (cnt_r == '0);
    cv1_r    <= coeff_vld_r[c_raddr];
    dv1_r    <= dly_vld_r[dptr_r];
    prod_r   <= PROD_W'(mul_a * mul_b);
    if (in_acc && (in_data.req_type == REQ_SAMPLE)) begin
      acc_r  <= '0;
      x_r    <= in_data.sample;
      taps_r <= taps_nxt;
    end else if (v2_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tap_count_r <= TAPCNT_W'(TAPCNT_RESET);
      coeff_vld_r <= '0;
      dly_vld_r   <= '0;
      head_r      <= '0;
      dptr_r      <= '0;
      cnt_r       <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        tap_count_r <= cfg_wr_data;
      end
      if (c_we) begin
        coeff_vld_r[c_waddr] <= 1'b1;
      end
      v1_r <= (state_r == S_RUN);
      v2_r <= v1_r;
      if (d_we) begin
        dly_vld_r[head_inc] <= 1'b1;
        head_r              <= head_inc;
        out_valid_r         <= 1'b1;
        out_data_r          <= res;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc && (in_data.req_type == REQ_SAMPLE)) begin
            cnt_r   <= '0;
            dptr_r  <= head_r;
            state_r <= S_RUN;
          end
        end
        S_RUN: begin
          cnt_r <= cnt_r + TW'(1);
          if (cnt_r != '0) begin
            dptr_r <= dptr_dec;
          end
          if (cnt_r == taps_r - TW'(1)) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!v1_r && !v2_r) begin
            state_r <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN) |-> (cnt_r < taps_r))
    else $error("tap counter ran past the tap count");

  a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FINISH))
    else $error("result raised outside the finish step");

  a_mac_busy: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |-> ((state_r == S_RUN) || (state_r == S_DRAIN)))
    else $error("mac pipeline active while not filtering");

  a_ring_range: assert property (@(posedge clk) disable iff (!rst_n)
    (head_r <= DAW'(DLY_D - 1)) && (dptr_r <= DAW'(DLY_D - 1)))
    else $error("history pointer outside the ring");

  a_sample_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_data.req_type == REQ_SAMPLE)) |=> (state_r == S_RUN))
    else $error("accepted sample did not start the mac sequence");

endmodule

@@ sim/tb_fir_filter.sv @@
// testbench for fir_filter: random and directed transactions checked against a predictor
module tb_fir_filter;
  import fir_pkg::*;

  localparam int MAX_TAPS    = 16;
  localparam int SETTLE_CYC  = 40;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 110;

  // running filter state and the outputs it still expects from the block
  class fir_tap_model;
    logic signed [COEFF_W-1:0]  coeffs[MAX_TAPS];
    logic signed [SAMPLE_W-1:0] history[MAX_TAPS-1];
    logic [TAPCNT_W-1:0]        tap_reg;
    fir_out_t                   pending_outputs[$];
    int mismatches;
    int n_samples;
    int n_coeff_writes;
    int n_checked;
    int n_clipped;

    function new();
      foreach (coeffs[i]) coeffs[i] = '0;
      foreach (history[i]) history[i] = '0;
      tap_reg = TAPCNT_W'(TAPCNT_RESET);
      mismatches = 0;
      n_samples = 0;
      n_coeff_writes = 0;
      n_checked = 0;
      n_clipped = 0;
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      if (mismatches <= 40) $display("%0t mismatch: %s", $time, msg);
    endtask

    function void take_request(fir_in_t req);
      longint   acc;
      int       taps;
      fir_out_t res;
      if (req.req_type == REQ_COEFF) begin
        coeffs[req.coeff_index] = req.coeff_value;
        n_coeff_writes++;
        return;
      end
      taps = int'(tap_reg);
      if (taps < 2) taps = 2;
      if (taps > MAX_TAPS) taps = MAX_TAPS;
      acc = longint'(coeffs[0]) * longint'(req.sample);
      for (int j = 1; j < taps; j++) begin
        acc += longint'(coeffs[j]) * longint'(history[j-1]);
      end
      // round half up, then floor to q1.15
      acc = (acc + 64'sd16384) >>> 15;
      res.clipped = 1'b0;
      if (acc > 64'sd32767) begin
        res.filtered = 16'sh7fff;
        res.clipped  = 1'b1;
      end else if (acc < -64'sd32768) begin
        res.filtered = 16'sh8000;
        res.clipped  = 1'b1;
      end else begin
        res.filtered = acc[15:0];
      end
      // the whole history shifts regardless of the tap count
      for (int j = MAX_TAPS - 2; j > 0; j--) history[j] = history[j-1];
      history[0] = req.sample;
      pending_outputs.push_back(res);
      n_samples++;
    endfunction

    task check_output(fir_out_t got);
      fir_out_t want;
      if (pending_outputs.size() == 0) begin
        report_mismatch($sformatf("unexpected result filtered=%0d clipped=%0b",
                                  got.filtered, got.clipped));
        return;
      end
      want = pending_outputs.pop_front();
      n_checked++;
      if (want.clipped) n_clipped++;
      if (got.filtered !== want.filtered)
        report_mismatch($sformatf("result %0d filtered: got %0d, expected %0d",
                                  n_checked, got.filtered, want.filtered));
      if (got.clipped !== want.clipped)
        report_mismatch($sformatf("result %0d clipped: got %0b, expected %0b",
                                  n_checked, got.clipped, want.clipped));
    endtask
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  fir_in_t             in_data;
  logic                out_valid;
  logic                out_stall;
  fir_out_t            out_data;
  logic                cfg_wr_en;
  logic [TAPCNT_W-1:0] cfg_wr_data;

  fir_tap_model model = new();
  int gap_pct;
  int stall_left;
  int cycles;
  int n_settings;

  fir_filter #(.MAX_TAPS(MAX_TAPS)) i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               model.pending_outputs.size());
      $display("** fir_filter: FAILED **");
      $finish;
    end
  end

  // result side: check accepted transactions, stall in short random bursts
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) model.check_output(out_data);
    if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(99) < gap_pct) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(2, 0);
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic logic [15:0] pick_value();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'h0001;
      4: return 16'hffff;
      5, 6: return 16'($urandom_range(4095)) - 16'd2048;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic fir_in_t noise_item();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[$bits(fir_in_t)-1:0];
  endfunction

  task automatic drive_in(fir_in_t req);
    if ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    model.take_request(req);
  endtask

  task automatic send_sample(logic [15:0] value);
    fir_in_t req;
    req          = noise_item();
    req.req_type = REQ_SAMPLE;
    req.sample   = value;
    drive_in(req);
  endtask

  task automatic send_coeff(logic [CIDX_W-1:0] idx, logic [15:0] value);
    fir_in_t req;
    req             = noise_item();
    req.req_type    = REQ_COEFF;
    req.coeff_index = idx;
    req.coeff_value = value;
    drive_in(req);
  endtask

  // stop sending until every result is back, then let the pipeline empty
  task automatic settle();
    in_valid <= 1'b0;
    while (model.pending_outputs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_taps(logic [TAPCNT_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en     <= 1'b0;
    model.tap_reg  = value;
    n_settings++;
  endtask

  initial begin
    logic [TAPCNT_W-1:0] tap_plan[10];
    int pause_at;
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_data     <= '0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    n_settings   = 0;
    gap_pct      = 30;
    tap_plan = '{5'd16, 5'd1, 5'd17, 5'd3, 5'd0, 5'd31, 5'd8, 5'd15, 5'd0, 5'd0};
    tap_plan[8] = TAPCNT_W'($urandom_range(31));
    tap_plan[9] = TAPCNT_W'($urandom_range(16, 2));
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset tap count: unwritten store, full-scale products, positive clip
    send_sample(16'h7fff);
    send_coeff(4'd0, 16'h8000);
    send_sample(16'h8000);
    send_sample(16'h7fff);
    send_sample(16'h0000);
    send_coeff(4'd1, 16'h8000);
    send_coeff(4'd15, 16'h7fff);
    send_coeff(4'd14, 16'hffff);
    send_sample(16'h8000);
    send_sample(16'h8000);
    send_sample(16'h0001);
    send_sample(16'hffff);
    settle();
    write_taps(5'd2);
    send_sample(16'h8000);
    send_sample(16'h8000);
    send_sample(16'h7fff);
    settle();
    // zero clamps to two taps; negative clip
    write_taps(5'd0);
    send_coeff(4'd0, 16'h7fff);
    send_coeff(4'd1, 16'h7fff);
    send_sample(16'h8000);
    send_sample(16'h8000);
    settle();
    write_taps(5'd31);
    send_sample(16'h3039);

    foreach (tap_plan[p]) begin
      settle();
      write_taps(tap_plan[p]);
      gap_pct  = (p == 9) ? 0 : (p % 4) * 20;
      pause_at = $urandom_range(PHASE_ITEMS - 10, 10);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k == pause_at && p != 9) settle();
        if ($urandom_range(99) < 20)
          send_coeff(4'($urandom_range(15)), pick_value());
        else
          send_sample(pick_value());
      end
    end
    settle();

    $display("covered %0d samples and %0d coefficient writes over %0d tap settings",
             model.n_samples, model.n_coeff_writes, n_settings);
    $display("checked %0d results, %0d of them saturated, %0d mismatches",
             model.n_checked, model.n_clipped, model.mismatches);
    if (model.mismatches == 0 && model.pending_outputs.size() == 0) begin
      $display("** fir_filter: PASSED **");
    end else begin
      $display("** fir_filter: FAILED **");
    end
    $finish;
  end

endmodule
